// ===== rtl/core/sjfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sjfs_pkg: shared types and constants of the SJF scheduler
// Widths, the store entry layout and the control state encoding.
// ----------------------------------------------------------------------------
package sjfs_pkg;

  localparam int MAX_PROC   = 64;
  localparam int IDX_W      = $clog2(MAX_PROC);
  localparam int CNT_W      = $clog2(MAX_PROC + 1);
  localparam int ID_W       = 8;
  localparam int BURST_W    = 16;
  localparam int TIME_W     = 22;
  localparam int TOTAL_W    = TIME_W + IDX_W;
  localparam int MEAN_W     = 30;
  localparam int DIVD_W     = TOTAL_W + 9;
  localparam int STEP_W     = $clog2(DIVD_W);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
  } entry_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CMP,
    S_PUT,
    S_SRD,
    S_SACC,
    S_DST,
    S_DIV,
    S_ORD,
    S_OUT
  } state_t;

endpackage

// ===== rtl/core/sjfs_div.sv =====
// ----------------------------------------------------------------------------
// sjfs_div: radix-2 restoring divider
// One quotient bit per cycle; divisor is a process count.
// ----------------------------------------------------------------------------
module sjfs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sjfs_pkg::DIVD_W-1:0] dividend,
  input  logic [sjfs_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [sjfs_pkg::DIVD_W-1:0] quotient
);
  import sjfs_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    rem_r;
  logic [DIVD_W-1:0]   quo_r;
  logic [CNT_W-1:0]    den_r;
  logic [CNT_W:0]      sh;
  logic [CNT_W+1:0]    diff;
  logic                ge;

  assign sh   = {rem_r, quo_r[DIVD_W-1]};
  assign diff = {1'b0, sh} - {2'b00, den_r};
  assign ge   = ~diff[CNT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && step_r == STEP_W'(DIVD_W - 1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= dividend;
      den_r  <= divisor;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      rem_r  <= ge ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
      quo_r  <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/shortest_job_first_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_unit: non-preemptive SJF scheduler
// Insertion: an input transaction walks the store memory downward, one entry
//   per cycle, moving each held entry with a larger burst up one place.
// Batch end: a totals pass over the store, the division, then the output pass.
// Throughput is set by the store memory walk (one write port, one read port).
// Reset clears count, drop flag, control and output valid; store is not cleared.
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sjfs_pkg::ID_W-1:0]    in_process_id,
  input  logic [sjfs_pkg::BURST_W-1:0] in_burst_length,
  input  logic                         in_batch_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sjfs_pkg::ID_W-1:0]    out_process_id,
  output logic [sjfs_pkg::BURST_W-1:0] out_burst,
  output logic [sjfs_pkg::TIME_W-1:0]  out_wait_length,
  output logic [sjfs_pkg::TIME_W-1:0]  out_turnaround_length,
  output logic [sjfs_pkg::MEAN_W-1:0]  out_mean_wait_q8,
  output logic [sjfs_pkg::MEAN_W-1:0]  out_mean_turnaround_q8,
  output logic                         out_final_result,
  output logic                         out_overflow_seen
);
  import sjfs_pkg::*;

  entry_t mem [MAX_PROC];
  entry_t rdata_r;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               drop_r, drop_nxt;
  entry_t             key_r, key_nxt;
  logic               end_r, end_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [TIME_W-1:0]  wait_r, wait_nxt;
  logic [TOTAL_W-1:0] tw_r, tw_nxt, tt_r, tt_nxt;
  logic [MEAN_W-1:0]  mw_r, mw_nxt, mt_r, mt_nxt;

  logic               ov_r, ov_nxt;
  entry_t             oe_r, oe_nxt;
  logic [TIME_W-1:0]  ow_r, ow_nxt, ot_r, ot_nxt;
  logic [MEAN_W-1:0]  omw_r, omw_nxt, omt_r, omt_nxt;
  logic               of_r, of_nxt, oo_r, oo_nxt;

  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  nt;
  logic [CNT_W-1:0]   idx_inc;
  logic               div_start, dw_done, dt_done;
  logic [DIVD_W-1:0]  dw_q, dt_q, dw_a, dt_a;

  assign sum     = {1'b0, wait_r} + (TIME_W+1)'(rdata_r.burst);
  assign nt      = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign idx_inc = idx_r + CNT_W'(1);
  assign dw_a    = {1'b0, tw_r, 8'h00} + DIVD_W'(cnt_r >> 1);
  assign dt_a    = {1'b0, tt_r, 8'h00} + DIVD_W'(cnt_r >> 1);

  sjfs_div u_div_w (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dw_a),
    .divisor(cnt_r), .done(dw_done), .quotient(dw_q)
  );

  sjfs_div u_div_t (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dt_a),
    .divisor(cnt_r), .done(dt_done), .quotient(dt_q)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    key_nxt   = key_r;
    end_nxt   = end_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    wait_nxt  = wait_r;
    tw_nxt    = tw_r;
    tt_nxt    = tt_r;
    mw_nxt    = mw_r;
    mt_nxt    = mt_r;
    ov_nxt    = ov_r && out_stall;
    oe_nxt    = oe_r;
    ow_nxt    = ow_r;
    ot_nxt    = ot_r;
    omw_nxt   = omw_r;
    omt_nxt   = omt_r;
    of_nxt    = of_r;
    oo_nxt    = oo_r;
    we        = 1'b0;
    waddr     = j_r;
    wdata     = key_r;
    raddr     = idx_r[IDX_W-1:0];
    div_start = 1'b0;
    in_stall  = (state_r != S_LOAD);

    unique case (state_r)
      S_LOAD: begin
        idx_nxt  = '0;
        wait_nxt = '0;
        tw_nxt   = '0;
        tt_nxt   = '0;
        if (in_valid) begin
          key_nxt = '{id: in_process_id, burst: in_burst_length};
          end_nxt = in_batch_end;
          if (cnt_r == CNT_W'(MAX_PROC)) begin
            drop_nxt  = 1'b1;
            state_nxt = in_batch_end ? S_SRD : S_LOAD;
          end else if (cnt_r == '0) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = '{id: in_process_id, burst: in_burst_length};
            cnt_nxt   = CNT_W'(1);
            state_nxt = in_batch_end ? S_SRD : S_LOAD;
          end else begin
            j_nxt     = cnt_r[IDX_W-1:0];
            raddr     = cnt_r[IDX_W-1:0] - IDX_W'(1);
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        we = 1'b1;
        if (rdata_r.burst > key_r.burst) begin
          wdata = rdata_r;
          j_nxt = j_r - IDX_W'(1);
          if (j_r == IDX_W'(1)) begin
            state_nxt = S_PUT;
          end else begin
            raddr = j_r - IDX_W'(2);
          end
        end else begin
          state_nxt = end_r ? S_SRD : S_LOAD;
        end
      end
      S_PUT: begin
        we        = 1'b1;
        waddr     = '0;
        state_nxt = end_r ? S_SRD : S_LOAD;
      end
      S_SRD: begin
        state_nxt = S_SACC;
      end
      S_SACC: begin
        tw_nxt    = tw_r + TOTAL_W'(wait_r);
        tt_nxt    = tt_r + TOTAL_W'(nt);
        wait_nxt  = nt;
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc == cnt_r) ? S_DST : S_SRD;
      end
      S_DST: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dw_done && dt_done) begin
          mw_nxt    = (dw_q > DIVD_W'(MEAN_MAX)) ? MEAN_MAX : dw_q[MEAN_W-1:0];
          mt_nxt    = (dt_q > DIVD_W'(MEAN_MAX)) ? MEAN_MAX : dt_q[MEAN_W-1:0];
          idx_nxt   = '0;
          wait_nxt  = '0;
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt   = 1'b1;
          oe_nxt   = rdata_r;
          ow_nxt   = wait_r;
          ot_nxt   = nt;
          omw_nxt  = mw_r;
          omt_nxt  = mt_r;
          of_nxt   = (idx_inc == cnt_r);
          oo_nxt   = drop_r;
          wait_nxt = nt;
          idx_nxt  = idx_inc;
          if (idx_inc == cnt_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    end_r  <= end_nxt;
    j_r    <= j_nxt;
    idx_r  <= idx_nxt;
    wait_r <= wait_nxt;
    tw_r   <= tw_nxt;
    tt_r   <= tt_nxt;
    mw_r   <= mw_nxt;
    mt_r   <= mt_nxt;
    oe_r   <= oe_nxt;
    ow_r   <= ow_nxt;
    ot_r   <= ot_nxt;
    omw_r  <= omw_nxt;
    omt_r  <= omt_nxt;
    of_r   <= of_nxt;
    oo_r   <= oo_nxt;
  end

  assign out_valid              = ov_r;
  assign out_process_id         = oe_r.id;
  assign out_burst              = oe_r.burst;
  assign out_wait_length        = ow_r;
  assign out_turnaround_length  = ot_r;
  assign out_mean_wait_q8       = omw_r;
  assign out_mean_turnaround_q8 = omt_r;
  assign out_final_result       = of_r;
  assign out_overflow_seen      = oo_r;

endmodule

// ===== verif/sjf_schedule_checker.sv =====
// ----------------------------------------------------------------------------
// sjf_schedule_checker: scoreboard for the SJF scheduler
// Collects each batch as its transactions are accepted, computes the sorted
// schedule with waits, turnarounds and Q8 averages, and compares it field by
// field with the result transactions.
// ----------------------------------------------------------------------------
module sjf_schedule_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [sjfs_pkg::ID_W-1:0]    in_process_id,
  input  logic [sjfs_pkg::BURST_W-1:0] in_burst_length,
  input  logic                         in_batch_end,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [sjfs_pkg::ID_W-1:0]    out_process_id,
  input  logic [sjfs_pkg::BURST_W-1:0] out_burst,
  input  logic [sjfs_pkg::TIME_W-1:0]  out_wait_length,
  input  logic [sjfs_pkg::TIME_W-1:0]  out_turnaround_length,
  input  logic [sjfs_pkg::MEAN_W-1:0]  out_mean_wait_q8,
  input  logic [sjfs_pkg::MEAN_W-1:0]  out_mean_turnaround_q8,
  input  logic                         out_final_result,
  input  logic                         out_overflow_seen,
  output int                           error_count,
  output int                           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sjfs_pkg::*;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  wait_len;
    logic [TIME_W-1:0]  turn_len;
    logic [MEAN_W-1:0]  mean_wait;
    logic [MEAN_W-1:0]  mean_turn;
    logic               last;
    logic               dropped;
  } sched_t;

  entry_t batch_q[$];
  logic   batch_dropped;
  sched_t schedule_q[$];

  function automatic logic [MEAN_W-1:0] q8_average(longint unsigned total, int n);
    longint unsigned m;
    m = (total * 256 + n / 2) / n;
    return (m > MEAN_MAX) ? MEAN_MAX : m[MEAN_W-1:0];
  endfunction

  task automatic build_schedule();
    entry_t          srt[$];
    entry_t          key;
    longint unsigned acc, w, t, tot_w, tot_t;
    logic [TIME_W-1:0] waits[$], turns[$];
    sched_t          s;
    int              j;
    srt = batch_q;
    for (int i = 1; i < srt.size(); i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1].burst > key.burst) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    acc = 0; tot_w = 0; tot_t = 0;
    foreach (srt[i]) begin
      w = (acc > TIME_MAX) ? TIME_MAX : acc;
      t = w + srt[i].burst;
      acc = t;
      if (t > TIME_MAX) t = TIME_MAX;
      waits.push_back(w[TIME_W-1:0]);
      turns.push_back(t[TIME_W-1:0]);
      tot_w += w;
      tot_t += t;
    end
    foreach (srt[i]) begin
      s.id = srt[i].id;
      s.burst = srt[i].burst;
      s.wait_len = waits[i];
      s.turn_len = turns[i];
      s.mean_wait = q8_average(tot_w, srt.size());
      s.mean_turn = q8_average(tot_t, srt.size());
      s.last = (i == srt.size() - 1);
      s.dropped = batch_dropped;
      schedule_q.push_back(s);
    end
    batch_q.delete();
    batch_dropped = 1'b0;
  endtask

  task automatic report(string what, longint got, longint exp_val);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, exp_val);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    pending_count = 0;
    batch_dropped = 1'b0;
  end

  always @(posedge clk) begin
    sched_t e;
    if (rst_n && in_valid && !in_stall) begin
      if (batch_q.size() < MAX_PROC) begin
        batch_q.push_back('{id: in_process_id, burst: in_burst_length});
      end else begin
        batch_dropped = 1'b1;
      end
      if (in_batch_end) build_schedule();
    end
    if (rst_n && out_valid && !out_stall) begin
      if (schedule_q.size() == 0) begin
        report("unexpected transaction id", out_process_id, 0);
      end else begin
        e = schedule_q.pop_front();
        if (out_process_id !== e.id) report("id", out_process_id, e.id);
        if (out_burst !== e.burst) report("burst", out_burst, e.burst);
        if (out_wait_length !== e.wait_len) report("wait", out_wait_length, e.wait_len);
        if (out_turnaround_length !== e.turn_len)
          report("turnaround", out_turnaround_length, e.turn_len);
        if (out_mean_wait_q8 !== e.mean_wait)
          report("mean wait", out_mean_wait_q8, e.mean_wait);
        if (out_mean_turnaround_q8 !== e.mean_turn)
          report("mean turnaround", out_mean_turnaround_q8, e.mean_turn);
        if (out_final_result !== e.last) report("final", out_final_result, e.last);
        if (out_overflow_seen !== e.dropped)
          report("overflow", out_overflow_seen, e.dropped);
      end
    end
    pending_count = schedule_q.size();
  end

endmodule

// ===== verif/shortest_job_first_scheduler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_unit_tb: stimulus and verdict
// Drives directed batches (ties, extremes, full store, overflow)
// then random batches with random gaps and output stalls; the checker does
// the comparison.
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sjfs_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ID_W-1:0]    in_process_id;
  logic [BURST_W-1:0] in_burst_length;
  logic               in_batch_end;
  logic               out_valid;
  logic               out_stall;
  logic [ID_W-1:0]    out_process_id;
  logic [BURST_W-1:0] out_burst;
  logic [TIME_W-1:0]  out_wait_length;
  logic [TIME_W-1:0]  out_turnaround_length;
  logic [MEAN_W-1:0]  out_mean_wait_q8;
  logic [MEAN_W-1:0]  out_mean_turnaround_q8;
  logic               out_final_result;
  logic               out_overflow_seen;
  int                 error_count;
  int                 pending_count;
  int                 idle_cycles;
  logic               stall_free;

  shortest_job_first_scheduler_unit DUT (.*);

  sjf_schedule_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high across back-to-back transactions; dropped only for a gap
  task automatic send_process(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                              logic last_flag);
    int   g;
    logic stalled;
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_process_id <= id;
    in_burst_length <= burst;
    in_batch_end <= last_flag;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  function automatic logic [BURST_W-1:0] random_burst();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return BURST_W'($urandom_range(0, 3));
    if (r < 4) return BURST_W'(16'hFFFF - $urandom_range(0, 3));
    if (r < 6) return BURST_W'($urandom_range(0, 15));
    return BURST_W'($urandom);
  endfunction

  task automatic send_batch(int n, int mode);
    logic [BURST_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: b = random_burst();
        1: b = 16'hFFFF;
        2: b = 16'd7;
        default: b = BURST_W'(16'hFFFF - i);
      endcase
      send_process(ID_W'($urandom), b, i == n - 1);
    end
  endtask

  // out_stall mostly low, occasionally long stalls; some stretches free
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_free <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
      if (stall_free) out_stall <= 1'b0;
      else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
      else if ($urandom_range(0, 99) < 30) out_stall <= 1'b0;
      else if (!out_stall) out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("shortest_job_first_scheduler_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_process_id = '0;
    in_burst_length = '0;
    in_batch_end = 1'b0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: single item, ties, extremes
    send_process(8'hFF, 16'hFFFF, 1'b1);
    send_process(8'h00, 16'h0000, 1'b1);
    send_process(8'h01, 16'd5, 1'b0);
    send_process(8'h02, 16'd3, 1'b0);
    send_process(8'h03, 16'd5, 1'b0);
    send_process(8'h04, 16'd3, 1'b0);
    send_process(8'hAA, 16'h0000, 1'b1);
    send_process(8'h55, 16'd1, 1'b0);
    send_process(8'h80, 16'd2, 1'b1);
    send_batch(6, 3);
    sent = 15;
    // full store, largest bursts
    send_batch(64, 1);
    sent += 64;
    // overflow: drops without and with batch end
    for (int i = 0; i < 64; i++) send_process(ID_W'(i), 16'd7, 1'b0);
    send_process(8'h11, 16'd1, 1'b0);
    send_process(8'h22, 16'd2, 1'b0);
    send_process(8'h33, 16'd3, 1'b1);
    sent += 67;
    while (sent < 350) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
      send_batch(n, ($urandom_range(0, 7) == 0) ? 2 : 0);
      sent += n;
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("shortest_job_first_scheduler_unit_tb: clean");
    end else begin
      $display("shortest_job_first_scheduler_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sjfs_pkg.sv
rtl/core/sjfs_div.sv
rtl/core/shortest_job_first_scheduler_unit.sv
verif/sjf_schedule_checker.sv
verif/shortest_job_first_scheduler_unit_tb.sv
